### hw/rtl/ped_pkg.sv
// ----------------------------------------------------------------------------
// ped_pkg
// types and constants shared by the pairwise distance block
// ----------------------------------------------------------------------------
package ped_pkg;

	localparam int MaxRowsDef   = 8;
	localparam int MaxLengthDef = 512;
	localparam int FracBitsDef  = 12;

	localparam logic [1:0] ModeLoadA   = 2'd0;
	localparam logic [1:0] ModeLoadB   = 2'd1;
	localparam logic [1:0] ModeCompute = 2'd2;

	localparam logic [1:0] RegRowsA = 2'd0;
	localparam logic [1:0] RegRowsB = 2'd1;
	localparam logic [1:0] RegVecLen = 2'd2;

	localparam int DistW = 21;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] feature;
	} req_t;

	typedef struct packed {
		logic [DistW-1:0] distance;
		logic [2:0]       row_a;
		logic [2:0]       row_b;
		logic             last;
	} res_t;

endpackage

### hw/rtl/ped_isqrt.sv
// ----------------------------------------------------------------------------
// ped_isqrt
// floor square root, one result bit per cycle, saturated to the output width
// ----------------------------------------------------------------------------
module ped_isqrt #(
	parameter int SumW = 42
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [SumW-1:0]           radicand,
	output logic                      done,
	output logic [ped_pkg::DistW-1:0] root
);
	import ped_pkg::*;

	localparam int RootW = (SumW + 1) / 2;
	localparam int CntW  = $clog2(RootW + 1);

	logic [RootW-1:0]  root_q;
	logic [RootW+1:0]  rem_q;
	logic [2*RootW-1:0] val_q;
	logic [CntW-1:0]   cnt_q;
	logic              busy_q;
	logic [RootW+1:0]  rem_sh;
	logic [RootW+1:0]  trial;

	assign rem_sh = {rem_q[RootW-1:0], val_q[2*RootW-1 -: 2]};
	assign trial  = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(RootW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			root_q <= '0;
			rem_q  <= '0;
			val_q  <= (2*RootW)'(radicand);
		end else if (busy_q) begin
			val_q <= val_q << 2;
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[RootW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[RootW-2:0], 1'b0};
			end
		end
	end

	generate
		if (RootW > DistW) begin : g_sat
			assign root = (|root_q[RootW-1:DistW]) ? {DistW{1'b1}} : root_q[DistW-1:0];
		end else begin : g_ext
			assign root = DistW'(root_q);
		end
	endgenerate

endmodule

### hw/rtl/pairwise_euclidean_distance.sv
// ----------------------------------------------------------------------------
// pairwise_euclidean_distance
// Loads two sets of signed fixed point vectors into on-chip stores and, on a
// compute request, emits the Euclidean distance of every pair of vectors.
// Loads may come back to back. A compute request keeps busy high while it
// walks the stores: for each pair it accumulates squared differences (one
// read of each store per feature, then the read pipe drains), then runs the
// shared bit-serial square root; a run keeps busy high until its last result.
// Results are strobed for one cycle with valid and cannot be held off by the
// receiver.
// ----------------------------------------------------------------------------
module pairwise_euclidean_distance #(
	parameter int MAX_ROWS   = ped_pkg::MaxRowsDef,
	parameter int MAX_LENGTH = ped_pkg::MaxLengthDef
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ped_pkg::req_t req,
	output logic          valid,
	output ped_pkg::res_t res,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [9:0]    cfg_data
);
	import ped_pkg::*;

	localparam int Depth = MAX_ROWS * MAX_LENGTH;
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int PosW  = $clog2(Depth + 1);
	localparam int LenW  = $clog2(MAX_LENGTH + 1);
	localparam int SumW  = 34 + $clog2(MAX_LENGTH + 1);

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StAcc  = 3'd1;
	localparam logic [2:0] StSqrt = 3'd2;
	localparam logic [2:0] StWait = 3'd3;

	logic [3:0] rows_a_q, rows_b_q;
	logic [9:0] vec_len_q;
	logic [3:0] ra, rb;
	logic [LenW-1:0] len;

	logic [15:0] mem_a [Depth];
	logic [15:0] mem_b [Depth];
	logic [15:0] rd_a_s1, rd_b_s1;

	logic [PosW-1:0] wpos_a_q, wpos_b_q;
	logic [PosW-1:0] lim_a, lim_b;

	logic [2:0]      state_q;
	logic [2:0]      ia_q, ib_q;
	logic [LenW-1:0] k_q;
	logic [AddrW-1:0] base_a_q, base_b_q;
	logic            rd_v_s1, rd_v_s2;
	logic [SumW-1:0] sum_q;
	logic [16:0]     diff_s2;
	logic            acc_last_s1, acc_last_s2;
	logic            sq_go, sq_done;
	logic [DistW-1:0] root;
	logic            acc_in;

	assign ra  = (rows_a_q > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : rows_a_q;
	assign rb  = (rows_b_q > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : rows_b_q;
	assign len = (32'(vec_len_q) > 32'(MAX_LENGTH)) ? LenW'(MAX_LENGTH) : LenW'(vec_len_q);
	assign lim_a = PosW'(ra) * PosW'(len);
	assign lim_b = PosW'(rb) * PosW'(len);

	assign busy = (state_q != StIdle);
	wire accept = start && !busy;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q  <= '0;
			rows_b_q  <= '0;
			vec_len_q <= 10'd512;
		end else if (cfg_we) begin
			case (cfg_index)
				RegRowsA:  rows_a_q  <= cfg_data[3:0];
				RegRowsB:  rows_b_q  <= cfg_data[3:0];
				RegVecLen: vec_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	wire wr_a = accept && req.mode == ModeLoadA && wpos_a_q < lim_a;
	wire wr_b = accept && req.mode == ModeLoadB && wpos_b_q < lim_b;

	// stores: one write and one registered read each
	wire [AddrW-1:0] rd_addr_a = AddrW'(base_a_q + AddrW'(k_q));
	wire [AddrW-1:0] rd_addr_b = AddrW'(base_b_q + AddrW'(k_q));
	always_ff @(posedge clk) begin
		if (wr_a) mem_a[wpos_a_q[AddrW-1:0]] <= req.feature;
		rd_a_s1 <= mem_a[rd_addr_a];
	end
	always_ff @(posedge clk) begin
		if (wr_b) mem_b[wpos_b_q[AddrW-1:0]] <= req.feature;
		rd_b_s1 <= mem_b[rd_addr_b];
	end

	assign acc_in = (state_q == StAcc) && (k_q < len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			wpos_a_q    <= '0;
			wpos_b_q    <= '0;
			ia_q        <= '0;
			ib_q        <= '0;
			k_q         <= '0;
			base_a_q    <= '0;
			base_b_q    <= '0;
			rd_v_s1     <= 1'b0;
			rd_v_s2     <= 1'b0;
			acc_last_s1 <= 1'b0;
			acc_last_s2 <= 1'b0;
			sq_go       <= 1'b0;
			valid       <= 1'b0;
		end else begin
			sq_go       <= 1'b0;
			valid       <= 1'b0;
			rd_v_s1     <= acc_in;
			rd_v_s2     <= rd_v_s1;
			acc_last_s1 <= (state_q == StAcc) && (k_q == len);
			acc_last_s2 <= acc_last_s1;
			if (wr_a) wpos_a_q <= wpos_a_q + 1'b1;
			if (wr_b) wpos_b_q <= wpos_b_q + 1'b1;
			case (state_q)
				StIdle: begin
					if (accept && req.mode == ModeCompute) begin
						wpos_a_q <= '0;
						wpos_b_q <= '0;
						if (ra != 4'd0 && rb != 4'd0) begin
							state_q  <= StAcc;
							ia_q     <= '0;
							ib_q     <= '0;
							k_q      <= '0;
							base_a_q <= '0;
							base_b_q <= '0;
						end
					end
				end
				StAcc: begin
					// walk features, then let the two-stage read pipe drain
					if (k_q < len) k_q <= k_q + 1'b1;
					else state_q <= StWait;
				end
				StWait: begin
					if (acc_last_s2) begin
						sq_go   <= 1'b1;
						state_q <= StSqrt;
					end
				end
				StSqrt: begin
					if (sq_done) begin
						valid <= 1'b1;
						k_q   <= '0;
						if ({1'b0, ib_q} + 4'd1 == rb) begin
							ib_q     <= '0;
							base_b_q <= '0;
							if ({1'b0, ia_q} + 4'd1 == ra) begin
								state_q <= StIdle;
							end else begin
								ia_q     <= ia_q + 1'b1;
								base_a_q <= AddrW'(base_a_q + AddrW'(len));
								state_q  <= StAcc;
							end
						end else begin
							ib_q     <= ib_q + 1'b1;
							base_b_q <= AddrW'(base_b_q + AddrW'(len));
							state_q  <= StAcc;
						end
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// difference stage, then square and accumulate
	always_ff @(posedge clk) begin
		diff_s2 <= $signed({rd_a_s1[15], rd_a_s1}) - $signed({rd_b_s1[15], rd_b_s1});
		if (state_q == StAcc && k_q == '0) sum_q <= '0;
		else if (rd_v_s2)
			sum_q <= sum_q + SumW'($unsigned(34'($signed(diff_s2)) * 34'($signed(diff_s2))));
	end

	ped_isqrt #(.SumW(SumW)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (sq_go),
		.radicand (sum_q),
		.done     (sq_done),
		.root     (root)
	);

	always_ff @(posedge clk) begin
		if (state_q == StSqrt && sq_done) begin
			res.distance <= root;
			res.row_a    <= ia_q;
			res.row_b    <= ib_q;
			res.last     <= ({1'b0, ib_q} + 4'd1 == rb) && ({1'b0, ia_q} + 4'd1 == ra);
		end
	end

endmodule

### hw/rtl/ped_checker.sv
// ----------------------------------------------------------------------------
// ped_checker
// port level checks on the pairwise distance block
// ----------------------------------------------------------------------------
module ped_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input ped_pkg::req_t req,
	input logic          valid,
	input ped_pkg::res_t res
);
	import ped_pkg::*;

	// a result only appears during a compute run
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy)) else $error("result outside compute run");

	// busy is already low while the last result is strobed
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && res.last) |-> !busy) else $error("busy after last result");

	// loads never make the block busy
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.mode != ModeCompute) |=> !busy)
		else $error("load started a run");

	// results never come back to back
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid) else $error("back to back results");

endmodule

bind pairwise_euclidean_distance ped_checker u_ped_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.req(req), .valid(valid), .res(res)
);

### tb/sv/pairwise_euclidean_distance_test.sv
// ----------------------------------------------------------------------------
// pairwise_euclidean_distance_test
// Loads feature sets through the request port, fires compute requests and
// checks every strobed distance against a local model of the stores, the
// write positions and the register layout. Directed cases cover reset state,
// field extremes, clamped and empty sizes, zero length, relayout and long
// vectors, then random well-formed load/compute phases with some noise.
// ----------------------------------------------------------------------------
module pairwise_euclidean_distance_test;
	import ped_pkg::*;

	localparam int StoreDepth = MaxRowsDef * MaxLengthDef;
	localparam logic [1:0] ModeUnused = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	req_t       req = '0;
	logic       valid;
	res_t       res;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = RegRowsA;
	logic [9:0] cfg_data = '0;

	pairwise_euclidean_distance u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.valid(valid), .res(res), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// local copy of the block state
	logic [3:0]  rows_a_reg = 4'd0;
	logic [3:0]  rows_b_reg = 4'd0;
	logic [9:0]  length_reg = 10'd512;
	logic [15:0] feat_a [StoreDepth];
	logic [15:0] feat_b [StoreDepth];
	bit          written_a [StoreDepth];
	bit          written_b [StoreDepth];
	int          pos_a = 0;
	int          pos_b = 0;

	res_t pending_distances [$];
	int   failures = 0;
	int   requests_sent = 0;
	bit   quiet = 1'b0;

	function automatic int eff_rows(input logic [3:0] r);
		return (r > MaxRowsDef) ? MaxRowsDef : int'(r);
	endfunction

	function automatic int eff_length();
		return (length_reg > MaxLengthDef) ? MaxLengthDef : int'(length_reg);
	endfunction

	function automatic longint unsigned sqrt_floor(input longint unsigned v);
		longint unsigned rem, root, b;
		rem = v;
		root = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic void predict_pairs();
		int ra, rb, len, d;
		longint unsigned acc, root;
		res_t r;
		ra = eff_rows(rows_a_reg);
		rb = eff_rows(rows_b_reg);
		len = eff_length();
		pos_a = 0;
		pos_b = 0;
		for (int i = 0; i < ra; i++)
			for (int j = 0; j < rb; j++) begin
				acc = 0;
				for (int k = 0; k < len; k++) begin
					d = int'($signed(feat_a[(i * len + k) % StoreDepth]))
						- int'($signed(feat_b[(j * len + k) % StoreDepth]));
					if (d < 0)
						d = -d;
					acc += longint'(d) * longint'(d);
				end
				root = sqrt_floor(acc);
				if (root > 64'h1FFFFF)
					root = 64'h1FFFFF;
				r.distance = root[DistW-1:0];
				r.row_a = i[2:0];
				r.row_b = j[2:0];
				r.last = (i + 1 == ra && j + 1 == rb);
				pending_distances.push_back(r);
			end
	endfunction

	function automatic void apply_request(input req_t r);
		int lim;
		case (r.mode)
			ModeLoadA: begin
				lim = eff_rows(rows_a_reg) * eff_length();
				if (pos_a < lim && pos_a < StoreDepth) begin
					feat_a[pos_a] = r.feature;
					written_a[pos_a] = 1'b1;
					pos_a++;
				end
			end
			ModeLoadB: begin
				lim = eff_rows(rows_b_reg) * eff_length();
				if (pos_b < lim && pos_b < StoreDepth) begin
					feat_b[pos_b] = r.feature;
					written_b[pos_b] = 1'b1;
					pos_b++;
				end
			end
			ModeCompute: predict_pairs();
			default: ;
		endcase
	endfunction

	// a compute must only read entries written since reset
	function automatic bit compute_safe();
		int la, lb;
		if (eff_rows(rows_a_reg) == 0 || eff_rows(rows_b_reg) == 0)
			return 1'b1;
		la = eff_rows(rows_a_reg) * eff_length();
		lb = eff_rows(rows_b_reg) * eff_length();
		for (int k = 0; k < la; k++)
			if (!written_a[k])
				return 1'b0;
		for (int k = 0; k < lb; k++)
			if (!written_b[k])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [15:0] rand_feature();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_gap();
		int p;
		if (quiet)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_request(input logic [1:0] mode, input logic [15:0] feat);
		req_t r;
		int gap;
		r.mode = mode;
		r.feature = feat;
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_request(r);
		requests_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the sender until every distance is in and the block has settled
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_distances.size() != 0 || busy)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_config(input int ra, input int rb, input int len);
		cfg_we <= 1'b1;
		cfg_index <= RegRowsA;
		cfg_data <= 10'(ra);
		@(posedge clk);
		cfg_index <= RegRowsB;
		cfg_data <= 10'(rb);
		@(posedge clk);
		cfg_index <= RegVecLen;
		cfg_data <= 10'(len);
		@(posedge clk);
		cfg_we <= 1'b0;
		rows_a_reg = 4'(ra);
		rows_b_reg = 4'(rb);
		length_reg = 10'(len);
	endtask

	task automatic fill_sets();
		int la, lb;
		la = eff_rows(rows_a_reg) * eff_length();
		lb = eff_rows(rows_b_reg) * eff_length();
		while (pos_a < la || pos_b < lb) begin
			if (pos_b >= lb || (pos_a < la && $urandom_range(0, 1) == 0))
				send_request(ModeLoadA, rand_feature());
			else
				send_request(ModeLoadB, rand_feature());
		end
	endtask

	task automatic test_reset_state();
		// rows are zero after reset: nothing comes back
		send_request(ModeCompute, 16'h0000);
		wait_idle();
	endtask

	task automatic test_extremes();
		set_config(1, 2, 2);
		send_request(ModeLoadA, 16'h7FFF);
		send_request(ModeLoadA, 16'h8000);
		send_request(ModeLoadB, 16'h8000);
		send_request(ModeLoadB, 16'h7FFF);
		send_request(ModeLoadB, 16'h7FFF);
		send_request(ModeLoadB, 16'h7FFF);
		// past the end of both sets
		send_request(ModeLoadA, 16'h1234);
		send_request(ModeLoadB, 16'hFFFF);
		send_request(ModeUnused, 16'hA5A5);
		send_request(ModeCompute, 16'hFFFF);
		wait_idle();
	endtask

	task automatic test_clamped_sizes();
		set_config(15, 0, 1023);
		send_request(ModeCompute, 16'h0000);
		wait_idle();
		set_config(15, 15, 1);
		fill_sets();
		send_request(ModeCompute, 16'h0000);
		wait_idle();
	endtask

	task automatic test_zero_length();
		set_config(3, 2, 0);
		send_request(ModeLoadA, 16'h0001);
		send_request(ModeCompute, 16'h0000);
		wait_idle();
	endtask

	task automatic test_relayout();
		set_config(2, 2, 4);
		fill_sets();
		wait_idle();
		// same loaded data read back with a different layout
		set_config(4, 4, 2);
		send_request(ModeCompute, 16'h0000);
		wait_idle();
	endtask

	task automatic test_long_vectors();
		quiet = 1'b1;
		set_config(1, 1, 120);
		fill_sets();
		send_request(ModeCompute, 16'h0000);
		wait_idle();
		quiet = 1'b0;
	endtask

	task automatic test_random(input int count);
		int stop_at, ra, rb, len, n;
		logic [1:0] m;
		stop_at = requests_sent + count;
		while (requests_sent < stop_at) begin
			if ($urandom_range(0, 4) != 0) begin
				wait_idle();
				quiet = ($urandom_range(0, 3) == 0);
				ra = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
				rb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
				case ($urandom_range(0, 9))
					0: len = 0;
					1: len = $urandom_range(7, 16);
					default: len = $urandom_range(1, 6);
				endcase
				set_config(ra, rb, len);
				fill_sets();
				repeat ($urandom_range(0, 2))
					send_request(2'($urandom_range(0, 1)), rand_feature());
				send_request(ModeCompute, 16'($urandom));
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					m = 2'($urandom_range(0, 3));
					if (m == ModeCompute && !compute_safe())
						m = ModeUnused;
					send_request(m, rand_feature());
				end
			end
		end
		wait_idle();
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && valid) begin
			if (pending_distances.size() == 0) begin
				$error("unexpected distance %0d row_a %0d row_b %0d", res.distance,
					res.row_a, res.row_b);
				failures++;
			end else begin
				res_t e;
				e = pending_distances.pop_front();
				if (res.distance !== e.distance) begin
					$error("distance: expected %0d, got %0d", e.distance, res.distance);
					failures++;
				end
				if (res.row_a !== e.row_a) begin
					$error("row_a: expected %0d, got %0d", e.row_a, res.row_a);
					failures++;
				end
				if (res.row_b !== e.row_b) begin
					$error("row_b: expected %0d, got %0d", e.row_b, res.row_b);
					failures++;
				end
				if (res.last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, res.last);
					failures++;
				end
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_extremes();
		test_clamped_sizes();
		test_zero_length();
		test_relayout();
		test_long_vectors();
		test_random(110);
		repeat (100) @(posedge clk);
		if (failures == 0 && pending_distances.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#(64'd12 * 64'd100000000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

### files.f
hw/rtl/ped_pkg.sv
hw/rtl/ped_isqrt.sv
hw/rtl/pairwise_euclidean_distance.sv
hw/rtl/ped_checker.sv
tb/sv/pairwise_euclidean_distance_test.sv
